/* design/mbps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared codes and types for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int LEN_W  = 9;
  localparam int RES_W  = 32;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic              scan;
    logic              restart;
    logic [BYTE_W-1:0] data_byte;
  } cell_ctrl_t;

endpackage

/* design/mbps_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell
// One pattern position: stored byte, care bit and prefix progress bit.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [mbps_pkg::BYTE_W-1:0] wr_byte,
  input  logic                      wr_care,
  input  mbps_pkg::cell_ctrl_t      ctrl,
  input  logic                      prev_in,
  input  logic                      is_last,
  output logic                      prog_out,
  output logic                      hit
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] pat;
  logic              care;
  logic              prog;
  logic              prog_next;
  logic              step;

  assign step     = prev_in && (!care || (pat == ctrl.data_byte));
  assign prog_out = prog;
  assign hit      = step && is_last;

  always_comb begin
    prog_next = prog;
    if (ctrl.restart) begin
      prog_next = 1'b0;
    end else if (ctrl.scan) begin
      prog_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog <= 1'b0;
    end else begin
      prog <= prog_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat  <= wr_byte;
      care <= wr_care;
    end
  end

endmodule

/* design/masked_byte_pattern_scanner_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core
// Wildcard byte signature scan over a row of pattern cells.
//
//   channel | bus     | content (low bit first)
//   --------+---------+------------------------------------------------------
//   input   | s_*     | tdata: entry_index, entry_byte, entry_care, data_byte
//           |         | tuser: operation   tlast: region_end
//   output  | m_*     | tdata: match_offset   tuser: found
//   config  | cfg_*   | cfg_wdata: pattern length
//
// Each transfer completes in its accept cycle: the cell row updates all
// progress bits and the result lands in the output register.
// One item per cycle is sustained; s_tready drops only while a result waits.
// Synchronous reset clears progress, position, done and output valid and sets
// pattern length to one; pattern cells keep what was loaded, undefined until written.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core #(
  parameter int PATTERN_MAX = 256,
  parameter int OFFSET_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // entry_index[7:0], entry_byte[15:8], entry_care[16], data_byte[24:17], rest unused
  input  logic [31:0]                  s_tdata,
  // operation[1:0]
  input  logic [mbps_pkg::OP_W-1:0]    s_tuser,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // match_offset[31:0]
  output logic [mbps_pkg::RES_W-1:0]   m_tdata,
  // found[0]
  output logic                         m_tuser,
  input  logic                         cfg_we,
  input  logic [mbps_pkg::LEN_W-1:0]   cfg_wdata
);
  import mbps_pkg::*;

  localparam int LW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int IW  = (LW > BYTE_W) ? LW : BYTE_W;
  localparam int FW  = 11;
  localparam logic [FW-1:0] PMAX = FW'(PATTERN_MAX);

  logic [LEN_W-1:0]       pat_len;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] pos_next;
  logic                   search_done;
  logic                   search_done_next;
  logic                   m_tvalid_next;

  logic                   accept;
  logic [BYTE_W-1:0]      entry_index;
  logic [BYTE_W-1:0]      entry_byte;
  logic                   entry_care;
  logic                   load_go;
  logic                   scan_go;
  logic                   restart_go;
  logic                   hit_any;
  logic                   res_load;
  logic [FW-1:0]          last_full;
  logic [LW-1:0]          last_idx;
  logic [OFFSET_BITS-1:0] start_pos;
  cell_ctrl_t             ctrl;

  logic [PATTERN_MAX-1:0] prog;
  logic [PATTERN_MAX-1:0] hit;

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign entry_index = s_tdata[7:0];
  assign entry_byte  = s_tdata[15:8];
  assign entry_care  = s_tdata[16];

  assign load_go    = accept && (s_tuser == OP_LOAD);
  assign restart_go = accept && (s_tuser == OP_RESTART);
  assign scan_go    = accept && (s_tuser == OP_SCAN) && !search_done;

  assign ctrl.scan      = scan_go;
  assign ctrl.restart   = restart_go;
  assign ctrl.data_byte = s_tdata[24:17];

  always_comb begin
    priority if (pat_len == '0) begin
      last_full = '0;
    end else if (FW'(pat_len) > PMAX) begin
      last_full = PMAX - FW'(1);
    end else begin
      last_full = FW'(pat_len) - FW'(1);
    end
  end
  assign last_idx = last_full[LW-1:0];

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = prog[k-1];
    end
    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (load_go && (IW'(entry_index) == IW'(k))),
      .wr_byte  (entry_byte),
      .wr_care  (entry_care),
      .ctrl     (ctrl),
      .prev_in  (prev),
      .is_last  (last_idx == LW'(k)),
      .prog_out (prog[k]),
      .hit      (hit[k])
    );
  end

  assign hit_any   = |hit;
  assign start_pos = pos - OFFSET_BITS'(last_full);
  assign res_load  = scan_go && (hit_any || s_tlast);

  always_comb begin
    pos_next         = pos;
    search_done_next = search_done;
    if (restart_go) begin
      pos_next         = '0;
      search_done_next = 1'b0;
    end else if (scan_go) begin
      pos_next = pos + OFFSET_BITS'(1);
      if (hit_any || s_tlast) begin
        search_done_next = 1'b1;
      end
    end
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (res_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len     <= LEN_W'(1);
      pos         <= '0;
      search_done <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        pat_len <= cfg_wdata;
      end
      pos         <= pos_next;
      search_done <= search_done_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= hit_any;
      m_tdata <= hit_any ? RES_W'(start_pos) : '0;
    end
  end

`ifndef SYNTHESIS
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser || (m_tdata == '0)))
    else $error("not-found result with nonzero offset");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res_load |=> search_done)
    else $error("search not marked done after a result");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (rst)
    search_done |-> !res_load)
    else $error("result produced after search done");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart_go |=> ((pos == '0) && !search_done && (prog == '0)))
    else $error("restart left scan state behind");
`endif

endmodule
